// File: rtl/nms_pkg.sv
// Shared types and constants for the box suppression block.
// Used by the ring cells, the overlap unit and the top level.
package nms_pkg;

  localparam int MAX_BOXES_DEF = 32;
  localparam int IDX_W         = 6;
  localparam int UNIT_STAGES   = 4;
  localparam int RANK_W        = 5;
  localparam logic [RANK_W-1:0] RANK_LAST = 5'd31;
  localparam logic [15:0] THR_RESET = 16'd32768;

  typedef struct packed {
    logic             alive;
    logic [IDX_W-1:0] idx;
    logic [15:0]      x;
    logic [15:0]      y;
    logic [15:0]      w;
    logic [15:0]      h;
    logic [15:0]      conf;
    logic [7:0]       cls;
  } box_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic flush;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_EMIT,
    ST_CLEAR
  } state_t;

endpackage

// File: rtl/nms_if.sv
// Valid/ready channel interfaces for box beats in and kept-box beats out.
// Depends on nothing.
interface nms_box_if;
  logic        valid;
  logic        ready;
  logic [15:0] box_x;
  logic [15:0] box_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [15:0] box_confidence;
  logic [7:0]  box_class;
  logic        last_box;

  modport source (output valid, box_x, box_y, box_width, box_height, box_confidence,
                  box_class, last_box, input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, box_confidence,
                box_class, last_box, output ready);
endinterface

interface nms_kept_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_x;
  logic [15:0] kept_y;
  logic [15:0] kept_width;
  logic [15:0] kept_height;
  logic [15:0] kept_confidence;
  logic [7:0]  kept_class;
  logic [4:0]  kept_rank;
  logic        last_kept;

  modport source (output valid, kept_x, kept_y, kept_width, kept_height, kept_confidence,
                  kept_class, kept_rank, last_kept, input ready);
  modport sink (input valid, kept_x, kept_y, kept_width, kept_height, kept_confidence,
                kept_class, kept_rank, last_kept, output ready);
endinterface

// File: rtl/nms_cell.sv
// One ring cell holding a stored box and its alive flag.
// Depends on nms_pkg.
module nms_cell
  import nms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ring_ctl_t ctl,
  input  box_t      d_in,
  output box_t      q
);

  box_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      q_r.alive <= 1'b0;
    end else if (ctl.shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/nms_iou_unit.sv
// Pipelined overlap test of each box passing through the ring against the current best box.
// Depends on nms_pkg.
module nms_iou_unit
  import nms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ring_ctl_t   ctl,
  input  box_t        d_in,
  input  box_t        best,
  input  logic        best_vld,
  input  logic [31:0] best_area,
  input  logic [15:0] thr,
  output box_t        d_out,
  output logic        fresh
);

  box_t        s1_e_r, s2_e_r, s3_e_r, s4_e_r;
  logic        s1_f_r, s2_f_r, s3_f_r, s4_f_r;
  logic        s1_ovl_r, s2_ovl_r, s3_ovl_r, s4_ovl_r;
  logic [15:0] s1_dx_r, s1_dy_r;
  logic [31:0] s2_inter_r, s3_inter_r, s4_inter_r;
  logic [31:0] s2_area_r;
  logic [32:0] s3_uni_r;
  logic [48:0] s4_rhs_r;

  logic [16:0] bx0, bx1, by0, by1, ex0, ex1, ey0, ey1;
  logic [16:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
  logic        ovl, kill;
  logic [48:0] lhs;

  always_comb begin
    bx0  = {1'b0, best.x};
    by0  = {1'b0, best.y};
    bx1  = bx0 + {1'b0, best.w};
    by1  = by0 + {1'b0, best.h};
    ex0  = {1'b0, d_in.x};
    ey0  = {1'b0, d_in.y};
    ex1  = ex0 + {1'b0, d_in.w};
    ey1  = ey0 + {1'b0, d_in.h};
    lo_x = (bx0 > ex0) ? bx0 : ex0;
    lo_y = (by0 > ey0) ? by0 : ey0;
    hi_x = (bx1 < ex1) ? bx1 : ex1;
    hi_y = (by1 < ey1) ? by1 : ey1;
    ovl  = (hi_x > lo_x) && (hi_y > lo_y);
    dx   = hi_x - lo_x;
    dy   = hi_y - lo_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      s1_e_r.alive <= 1'b0;
      s2_e_r.alive <= 1'b0;
      s3_e_r.alive <= 1'b0;
      s4_e_r.alive <= 1'b0;
      s1_f_r       <= 1'b0;
      s2_f_r       <= 1'b0;
      s3_f_r       <= 1'b0;
      s4_f_r       <= 1'b0;
    end else if (ctl.flush) begin
      s1_f_r <= 1'b0;
      s2_f_r <= 1'b0;
      s3_f_r <= 1'b0;
      s4_f_r <= 1'b0;
    end else if (ctl.shift) begin
      s1_e_r     <= d_in;
      s1_ovl_r   <= ovl;
      s1_dx_r    <= dx[15:0];
      s1_dy_r    <= dy[15:0];
      s2_e_r     <= s1_e_r;
      s2_ovl_r   <= s1_ovl_r;
      s2_inter_r <= s1_dx_r * s1_dy_r;
      s2_area_r  <= s1_e_r.w * s1_e_r.h;
      s3_e_r     <= s2_e_r;
      s3_ovl_r   <= s2_ovl_r;
      s3_inter_r <= s2_inter_r;
      s3_uni_r   <= {1'b0, best_area} + {1'b0, s2_area_r} - {1'b0, s2_inter_r};
      s4_e_r     <= s3_e_r;
      s4_ovl_r   <= s3_ovl_r;
      s4_inter_r <= s3_inter_r;
      s4_rhs_r   <= thr * s3_uni_r;
      s1_f_r     <= 1'b1;
      s2_f_r     <= s1_f_r;
      s3_f_r     <= s2_f_r;
      s4_f_r     <= s3_f_r;
    end
  end

  always_comb begin
    lhs  = {1'b0, s4_inter_r, 16'd0};
    kill = s4_f_r && best_vld &&
           ((s4_e_r.idx == best.idx) || (s4_ovl_r && (lhs > s4_rhs_r)));
    d_out       = s4_e_r;
    d_out.alive = s4_e_r.alive && !kill;
  end

  assign fresh = s4_f_r;

endmodule

// File: rtl/bbox_non_max_suppression.sv
// Greedy non-maximum suppression over up to MAX_BOXES boxes held in a ring of cells.
// Loading accepts one box beat per cycle. After the last box, each suppression round rotates
// the ring once through the four-stage overlap unit. The first kept box is chosen in the first
// round and is sent out at the end of the second round.
// Reset is synchronous and active low; it empties the store and sets the threshold to one half.
module bbox_non_max_suppression
  import nms_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  nms_box_if.sink     in_box,
  nms_kept_if.source  out_kept
);

  localparam int CNT_W    = $clog2(MAX_BOXES + 1);
  localparam int PASS_LEN = MAX_BOXES + 2 * UNIT_STAGES;
  localparam int PASS_W   = $clog2(PASS_LEN);

  state_t state_r, state_nxt;

  logic [15:0]       thr_r;
  logic [CNT_W-1:0]  load_cnt_r;
  logic [PASS_W-1:0] pass_cnt_r;
  logic [RANK_W-1:0] rank_r;
  box_t              best_r, cand_r, load_box;
  logic              best_vld_r, cand_vld_r;
  logic [31:0]       best_area_r;

  logic        out_vld_r, out_last_r;
  box_t        out_box_r;
  logic [RANK_W-1:0] out_rank_r;

  ring_ctl_t cell_ctl, unit_ctl;
  box_t      cell_q [MAX_BOXES];
  box_t      cell_d [MAX_BOXES];
  box_t      unit_out;
  logic      unit_fresh;

  logic in_acc, load_shift, pass_shift, emit_go, out_free, is_last, better;

  assign out_free   = !out_vld_r || out_kept.ready;
  assign in_box.ready = (state_r == ST_LOAD);
  assign in_acc     = in_box.valid && in_box.ready;
  assign load_shift = in_acc && (load_cnt_r < CNT_W'(MAX_BOXES));
  assign pass_shift = (state_r == ST_PASS);
  assign emit_go    = (state_r == ST_EMIT) && (!best_vld_r || out_free);
  assign is_last    = !cand_vld_r || (rank_r == RANK_LAST);

  always_comb begin
    load_box.alive = 1'b1;
    load_box.idx   = IDX_W'(load_cnt_r);
    load_box.x     = in_box.box_x;
    load_box.y     = in_box.box_y;
    load_box.w     = in_box.box_width;
    load_box.h     = in_box.box_height;
    load_box.conf  = in_box.box_confidence;
    load_box.cls   = in_box.box_class;
  end

  always_comb begin
    cell_ctl.shift = load_shift || pass_shift;
    cell_ctl.clear = (state_r == ST_CLEAR);
    cell_ctl.flush = 1'b0;
    unit_ctl.shift = pass_shift;
    unit_ctl.clear = (state_r == ST_CLEAR);
    unit_ctl.flush = emit_go;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_BOXES; g++) begin : g_ring
      if (g == 0) begin : g_head
        assign cell_d[g] = (state_r == ST_LOAD) ? load_box : unit_out;
      end else begin : g_body
        assign cell_d[g] = cell_q[g-1];
      end
      nms_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl),
        .d_in  (cell_d[g]),
        .q     (cell_q[g])
      );
    end
  endgenerate

  nms_iou_unit u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (unit_ctl),
    .d_in      (cell_q[MAX_BOXES-1]),
    .best      (best_r),
    .best_vld  (best_vld_r),
    .best_area (best_area_r),
    .thr       (thr_r),
    .d_out     (unit_out),
    .fresh     (unit_fresh)
  );

  assign better = unit_fresh && unit_out.alive &&
                  (!cand_vld_r || (unit_out.conf > cand_r.conf) ||
                   ((unit_out.conf == cand_r.conf) && (unit_out.idx < cand_r.idx)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_box.last_box) state_nxt = ST_PASS;
      end
      ST_PASS: begin
        if (pass_cnt_r == PASS_W'(PASS_LEN - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (best_vld_r) state_nxt = is_last ? ST_CLEAR : ST_PASS;
          else            state_nxt = cand_vld_r ? ST_PASS : ST_CLEAR;
        end
      end
      ST_CLEAR: state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      thr_r      <= THR_RESET;
      load_cnt_r <= '0;
      pass_cnt_r <= '0;
      rank_r     <= '0;
      best_vld_r <= 1'b0;
      cand_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      if (pass_shift) pass_cnt_r <= pass_cnt_r + 1'b1;
      else            pass_cnt_r <= '0;
      if (state_r == ST_CLEAR) begin
        load_cnt_r <= '0;
        rank_r     <= '0;
        best_vld_r <= 1'b0;
        cand_vld_r <= 1'b0;
      end else begin
        if (load_shift) load_cnt_r <= load_cnt_r + 1'b1;
        if (emit_go) begin
          cand_vld_r <= 1'b0;
          best_vld_r <= cand_vld_r;
          if (best_vld_r) rank_r <= rank_r + 1'b1;
        end else if (pass_shift && better) begin
          cand_vld_r <= 1'b1;
        end
      end
      if (emit_go && best_vld_r) out_vld_r <= 1'b1;
      else if (out_kept.ready)   out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_shift && better) cand_r <= unit_out;
    if (emit_go) begin
      best_r      <= cand_r;
      best_area_r <= cand_r.w * cand_r.h;
      if (best_vld_r) begin
        out_box_r  <= best_r;
        out_rank_r <= rank_r;
        out_last_r <= is_last;
      end
    end
  end

  assign out_kept.valid           = out_vld_r;
  assign out_kept.kept_x          = out_box_r.x;
  assign out_kept.kept_y          = out_box_r.y;
  assign out_kept.kept_width      = out_box_r.w;
  assign out_kept.kept_height     = out_box_r.h;
  assign out_kept.kept_confidence = out_box_r.conf;
  assign out_kept.kept_class      = out_box_r.cls;
  assign out_kept.kept_rank       = out_rank_r;
  assign out_kept.last_kept       = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CNT_W'(MAX_BOXES))
    else $error("load count beyond capacity");
  a_pass_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PASS |=> (state_r == ST_PASS || state_r == ST_EMIT))
    else $error("round left early");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> (!cand_vld_r && !best_vld_r))
    else $error("stale candidate while loading");
`endif

endmodule
